[hw/rtl/block_lz_decompressor_defines.svh]
// Assertion macros shared by the decompressor modules.
`ifndef BLOCK_LZ_DECOMPRESSOR_DEFINES_SVH
`define BLOCK_LZ_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/blz_pkg.sv]
// Package: constants, codes and control types of the LZ block decompressor.
package blz_pkg;

  localparam int unsigned BLOCK_TOKENS     = 16;
  localparam int unsigned MIN_MATCH_LEN    = 3;
  localparam int unsigned LONG_OFFSET_BASE = 1792;
  localparam int unsigned WINDOW_DEPTH     = 131072;

  localparam logic [7:0] LEN_MASK  = 8'h1f;
  localparam logic [7:0] LONG_MARK = 8'he0;
  localparam int unsigned BYTE_BITS = 8;

  // Register index taken from the configuration address.
  localparam logic REG_RAW_SIZE = 1'b0;

  typedef enum logic [1:0] {
    PH_FLAGS, PH_TOKENS, PH_EXTRAS, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK, ST_TRUNC, ST_LEN, ST_OFFSET
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_MCHECK, S_CREAD, S_CEMIT, S_RUN, S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic mcheck;
    logic cread;
    logic cemit;
    logic cdone;
    logic remit;
    logic rstop;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tokens_full;
    logic match_ready;
    logic ofs_bad;
    logic copy_more;
    logic run_more;
    logic run_flag;
    logic emit_ok;
    logic fin_ok;
  } dp_status_t;

endpackage

[hw/rtl/blz_if.sv]
// Stream interfaces: compressed input beats and raw output beats.
interface blz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] comp_byte;
  logic       is_final;
  modport source (output valid, comp_byte, is_final, input ready);
  modport sink   (input valid, comp_byte, is_final, output ready);
endinterface

interface blz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       has_byte;
  logic       run_end;
  logic       finished;
  logic [1:0] status;
  modport source (output valid, raw_byte, has_byte, run_end, finished, status, input ready);
  modport sink   (input valid, raw_byte, has_byte, run_end, finished, status, output ready);
endinterface

[hw/rtl/blz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module blz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/blz_ctrl.sv]
// Controller state machine: sequences each input beat through the datapath.
`include "block_lz_decompressor_defines.svh"
module blz_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blz_pkg::dp_status_t status_i,
  output blz_pkg::ctrl_cmd_t  cmd_o
);
  import blz_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        if (status_i.tokens_full) begin
          state_d = S_RUN;
        end else if (status_i.match_ready) begin
          state_d = S_MCHECK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MCHECK: begin
        cmd_o.mcheck = 1'b1;
        state_d      = status_i.ofs_bad ? S_FINISH : S_CREAD;
      end
      S_CREAD: begin
        if (status_i.copy_more) begin
          cmd_o.cread = 1'b1;
          state_d     = S_CEMIT;
        end else begin
          cmd_o.cdone = 1'b1;
          state_d     = S_RUN;
        end
      end
      S_CEMIT: begin
        if (status_i.emit_ok) begin
          cmd_o.cemit = 1'b1;
          state_d     = S_CREAD;
        end
      end
      S_RUN: begin
        if (status_i.run_more && !status_i.run_flag) begin
          cmd_o.remit = status_i.emit_ok;
        end else begin
          cmd_o.rstop = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.fin_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `BLZ_ASSERT_NXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == S_DISPATCH,
                  "accepted beat not dispatched")
  `BLZ_ASSERT_IMP(a_cemit_after_read, state_q == S_CEMIT,
                  $past(state_q) == S_CREAD || $past(state_q) == S_CEMIT,
                  "copy emit without a window read")
  `BLZ_ASSERT_IMP(a_ready_only_idle, in_ready_o, state_q == S_IDLE,
                  "input ready outside idle")
endmodule

[hw/rtl/blz_datapath.sv]
// Datapath: block buffers, stream counters, window RAM and output staging.
`include "block_lz_decompressor_defines.svh"
module blz_datapath #(
  parameter int unsigned BLOCK_TOKENS     = blz_pkg::BLOCK_TOKENS,
  parameter int unsigned MIN_MATCH_LEN    = blz_pkg::MIN_MATCH_LEN,
  parameter int unsigned LONG_OFFSET_BASE = blz_pkg::LONG_OFFSET_BASE,
  parameter int unsigned WINDOW_DEPTH     = blz_pkg::WINDOW_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blz_pkg::ctrl_cmd_t  cmd_i,
  output blz_pkg::dp_status_t status_o,
  input  logic [7:0]          comp_byte_i,
  input  logic                is_final_i,
  input  logic [30:0]         raw_size_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          raw_byte_o,
  output logic                has_byte_o,
  output logic                run_end_o,
  output logic                finished_o,
  output logic [1:0]          out_status_o
);
  import blz_pkg::*;

  localparam int unsigned CTRL_BYTES = (BLOCK_TOKENS + 7) / 8;
  localparam int unsigned FLW = BYTE_BITS * CTRL_BYTES;
  localparam int unsigned FIW = $clog2(FLW);
  localparam int unsigned TW  = $clog2(BLOCK_TOKENS);
  localparam int unsigned FW  = $clog2(BLOCK_TOKENS + 1);
  localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned OW  = $clog2(65536 + LONG_OFFSET_BASE);
  localparam int unsigned LW  = $clog2(32 + MIN_MATCH_LEN);

  logic [7:0]     byte_q, byte_d;
  logic           fin_q, fin_d;
  phase_e         phase_q, phase_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [FW-1:0]  pos_q, pos_d;
  logic [FLW-1:0] flags_q, flags_d;
  logic [7:0]     low_q, low_d;
  logic           seen_q, seen_d;
  logic [31:0]    oc_q, oc_d;
  logic [31:0]    bs_q, bs_d;
  status_e        err_q, err_d;
  logic [AW-1:0]  src_q, src_d;
  logic [LW-1:0]  len_q, len_d;
  logic [LW-1:0]  cnt_q, cnt_d;
  logic           pend_v_q, pend_v_d;
  logic [7:0]     pend_byte_q, pend_byte_d;
  logic           out_v_q, out_v_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           out_has_q, out_has_d;
  logic           out_end_q, out_end_d;
  logic           out_fin_q, out_fin_d;
  status_e        out_st_q, out_st_d;
  logic [7:0]     tok_mem_q [BLOCK_TOKENS];

  logic [7:0]    tok;
  logic          tok_long;
  logic          tok_we;
  phase_e        phase_eff;
  logic          oc_ge_raw;
  logic [OW-1:0] ofs;
  logic [FW-1:0] fill_inc;
  logic          can_emit;
  logic          emit_now;
  logic [7:0]    emit_byte;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  status_e       final_st;

  blz_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk_i   (clk_i),
    .we_i    (emit_now),
    .waddr_i (oc_q[AW-1:0]),
    .wdata_i (emit_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    tok       = tok_mem_q[pos_q[TW-1:0]];
    tok_long  = (tok & LONG_MARK) == LONG_MARK;
    oc_ge_raw = oc_q >= {1'b0, raw_size_i};
    phase_eff = (phase_q == PH_FLAGS && fill_q == '0 && oc_ge_raw) ? PH_DONE : phase_q;
    ofs       = tok_long ? (OW'({byte_q, low_q}) + OW'(LONG_OFFSET_BASE))
                         : OW'({tok[7:5], byte_q});
    fill_inc  = fill_q + 1'b1;
    can_emit  = !out_v_q || out_ready_i;

    status_o.tokens_full = phase_eff == PH_TOKENS && fill_inc >= FW'(BLOCK_TOKENS);
    status_o.match_ready = phase_eff == PH_EXTRAS && (!tok_long || seen_q);
    status_o.ofs_bad     = 32'(ofs) > bs_q;
    status_o.copy_more   = cnt_q < len_q && !oc_ge_raw;
    status_o.run_more    = pos_q < FW'(BLOCK_TOKENS) && !oc_ge_raw;
    status_o.run_flag    = flags_q[pos_q[FIW-1:0]];
    status_o.emit_ok     = !pend_v_q || can_emit;
    status_o.fin_ok      = (fin_q || pend_v_q) ? can_emit : 1'b1;

    if (err_q != ST_OK) begin
      final_st = err_q;
    end else if (phase_q == PH_DONE) begin
      final_st = ST_OK;
    end else if (phase_q == PH_FLAGS && fill_q == '0) begin
      final_st = ST_LEN;
    end else begin
      final_st = ST_TRUNC;
    end
  end

  always_comb begin
    byte_d      = byte_q;
    fin_d       = fin_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    flags_d     = flags_q;
    low_d       = low_q;
    seen_d      = seen_q;
    oc_d        = oc_q;
    bs_d        = bs_q;
    err_d       = err_q;
    src_d       = src_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_byte_d = pend_byte_q;
    out_v_d     = out_v_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_end_d   = out_end_q;
    out_fin_d   = out_fin_q;
    out_st_d    = out_st_q;
    tok_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = src_q + AW'(cnt_q);
    emit_now    = cmd_i.cemit || cmd_i.remit;
    emit_byte   = cmd_i.cemit ? ram_rdata : tok;

    if (cmd_i.accept) begin
      byte_d = comp_byte_i;
      fin_d  = is_final_i;
    end

    if (cmd_i.dispatch) begin
      phase_d = phase_eff;
      case (phase_eff)
        PH_FLAGS: begin
          for (int k = 0; k < CTRL_BYTES; k++) begin
            if (fill_q == FW'(k)) begin
              flags_d[k*BYTE_BITS +: BYTE_BITS] = flags_q[k*BYTE_BITS +: BYTE_BITS] | byte_q;
            end
          end
          fill_d = fill_inc;
          if (fill_inc >= FW'(CTRL_BYTES)) begin
            fill_d  = '0;
            phase_d = PH_TOKENS;
          end
        end
        PH_TOKENS: begin
          tok_we = 1'b1;
          fill_d = fill_inc;
          if (fill_inc >= FW'(BLOCK_TOKENS)) begin
            fill_d = '0;
            pos_d  = '0;
            bs_d   = oc_q;
          end
        end
        PH_EXTRAS: begin
          if (!status_o.match_ready) begin
            low_d  = byte_q;
            seen_d = 1'b1;
          end
        end
        PH_DONE: begin
          if (err_q == ST_OK) begin
            err_d = ST_LEN;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (cmd_i.mcheck) begin
      if (status_o.ofs_bad) begin
        if (err_q == ST_OK) begin
          err_d = ST_OFFSET;
        end
        phase_d = PH_DONE;
      end else begin
        src_d = AW'(bs_q - 32'(ofs));
        len_d = LW'(tok & LEN_MASK) + LW'(MIN_MATCH_LEN);
        cnt_d = '0;
      end
    end

    if (cmd_i.cread) begin
      ram_re = 1'b1;
    end

    // Stage the new byte; the byte staged before it moves to the output.
    if (emit_now) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = pend_byte_q;
        out_has_d  = 1'b1;
        out_end_d  = 1'b0;
        out_fin_d  = 1'b0;
        out_st_d   = ST_OK;
      end
      pend_v_d    = 1'b1;
      pend_byte_d = emit_byte;
      oc_d        = oc_q + 32'd1;
    end

    if (cmd_i.cemit) begin
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_i.cdone) begin
      pos_d  = pos_q + 1'b1;
      seen_d = 1'b0;
      low_d  = '0;
    end

    if (cmd_i.remit) begin
      pos_d = pos_q + 1'b1;
    end

    if (cmd_i.rstop) begin
      if (status_o.run_more && status_o.run_flag) begin
        phase_d = PH_EXTRAS;
        seen_d  = 1'b0;
        low_d   = '0;
      end else if (oc_ge_raw) begin
        phase_d = PH_DONE;
      end else begin
        phase_d = PH_FLAGS;
        flags_d = '0;
        fill_d  = '0;
      end
    end

    if (cmd_i.finish) begin
      if (fin_q || pend_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = pend_v_q ? pend_byte_q : 8'd0;
        out_has_d  = pend_v_q;
        out_end_d  = 1'b1;
        out_fin_d  = fin_q;
        out_st_d   = fin_q ? final_st : ST_OK;
      end
      pend_v_d = 1'b0;
      if (fin_q) begin
        phase_d = PH_FLAGS;
        flags_d = '0;
        fill_d  = '0;
        pos_d   = '0;
        low_d   = '0;
        seen_d  = 1'b0;
        oc_d    = '0;
        bs_d    = '0;
        err_d   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FLAGS;
      fill_q   <= '0;
      pos_q    <= '0;
      flags_q  <= '0;
      low_q    <= '0;
      seen_q   <= 1'b0;
      oc_q     <= '0;
      bs_q     <= '0;
      err_q    <= ST_OK;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      flags_q  <= flags_d;
      low_q    <= low_d;
      seen_q   <= seen_d;
      oc_q     <= oc_d;
      bs_q     <= bs_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    fin_q       <= fin_d;
    src_q       <= src_d;
    len_q       <= len_d;
    cnt_q       <= cnt_d;
    pend_byte_q <= pend_byte_d;
    out_byte_q  <= out_byte_d;
    out_has_q   <= out_has_d;
    out_end_q   <= out_end_d;
    out_fin_q   <= out_fin_d;
    out_st_q    <= out_st_d;
    if (tok_we) begin
      tok_mem_q[fill_q[TW-1:0]] <= byte_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign raw_byte_o   = out_byte_q;
  assign has_byte_o   = out_has_q;
  assign run_end_o    = out_end_q;
  assign finished_o   = out_fin_q;
  assign out_status_o = out_st_q;

  `BLZ_ASSERT_IMP(a_emit_slot, cmd_i.cemit || cmd_i.remit, !pend_v_q || can_emit,
                  "emit with no room for the staged byte")
  `BLZ_ASSERT_IMP(a_finish_slot, cmd_i.finish && (fin_q || pend_v_q), can_emit,
                  "finish with output register full")
  `BLZ_ASSERT_IMP(a_status_only_final, out_v_q && !out_has_q, out_fin_q && out_end_q,
                  "status-only beat not final")
endmodule

[hw/rtl/block_lz_decompressor.sv]
// Top level of the LZ block decompressor: config register, controller and datapath.
//
// Usage: compressed bytes enter as beats on in_i (comp_byte, is_final), one byte per
// beat; rebuilt raw bytes leave as beats on out_o. Each input beat yields zero or more
// output beats; the last one carries run_end. A beat with is_final set ends the stream:
// its last output beat carries finished and the status (ok, truncated block, length
// mismatch, offset before output start), added as a status-only beat if no byte came.
// raw_size is written over the APB port at byte address 0; the user must write it only
// while the block is idle, since the block itself does not enforce it. A control, token
// or first long-offset beat passes through accept, dispatch and finish. The last token
// beat of a block replays its literals at one byte per cycle while the output takes
// them, then stops the run. A match beat adds an offset check, a registered window read
// and then a write of the emitted byte for each copied byte, a step to close the copy
// and then the literal run; a bad offset goes straight to finish. One byte is staged
// ahead so that run_end can be marked on the true last beat.
// Reset clears the stream phase, counters, flags, error status and raw_size; the window
// RAM is not cleared, so a copy may read back bytes left from an earlier stream.
// When the receiver stalls, the output register holds its beat, the staged byte waits
// behind it and the controller stalls; input is taken again once the beat is finished.
module block_lz_decompressor #(
  parameter int unsigned BLOCK_TOKENS     = blz_pkg::BLOCK_TOKENS,
  parameter int unsigned MIN_MATCH_LEN    = blz_pkg::MIN_MATCH_LEN,
  parameter int unsigned LONG_OFFSET_BASE = blz_pkg::LONG_OFFSET_BASE,
  parameter int unsigned WINDOW_DEPTH     = blz_pkg::WINDOW_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blz_in_if.sink      in_i,
  blz_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import blz_pkg::*;

  ctrl_cmd_t   cmd;
  dp_status_t  dp_status;
  logic [30:0] raw_size_q;
  logic        cfg_hit;

  // Only one register: bit 2 of the byte address selects it.
  assign cfg_hit = paddr[2] == REG_RAW_SIZE;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {1'b0, raw_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_size_q <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      raw_size_q <= pwdata[30:0];
    end
  end

  // Sequence each beat through dispatch, match copy, literal replay and finish.
  blz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  blz_datapath #(
    .BLOCK_TOKENS     (BLOCK_TOKENS),
    .MIN_MATCH_LEN    (MIN_MATCH_LEN),
    .LONG_OFFSET_BASE (LONG_OFFSET_BASE),
    .WINDOW_DEPTH     (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .comp_byte_i  (in_i.comp_byte),
    .is_final_i   (in_i.is_final),
    .raw_size_i   (raw_size_q),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .raw_byte_o   (out_o.raw_byte),
    .has_byte_o   (out_o.has_byte),
    .run_end_o    (out_o.run_end),
    .finished_o   (out_o.finished),
    .out_status_o (out_o.status)
  );
endmodule

[dv/blz_scoreboard.sv]
`timescale 1ns / 1ps
// Checker: predicts the raw beats of the decompressor and compares the output beats.
module blz_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  blz_in_if           in_mon,
  blz_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import blz_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       fin;
    status_e    st;
  } raw_beat_t;

  raw_beat_t   awaited_q[$];
  raw_beat_t   step_beats[$];

  logic [7:0]  window_mem [WINDOW_DEPTH];
  logic [7:0]  tok_mem [BLOCK_TOKENS];
  logic [15:0] flags;
  phase_e      ph;
  int unsigned fill, tpos, out_cnt, blk_start, raw_sz;
  logic [7:0]  lo_ext;
  bit          ext_seen;
  status_e     err;

  function automatic void put_beat(logic [7:0] d, logic h);
    raw_beat_t e;
    e.data = d;
    e.has  = h;
    e.last = 1'b0;
    e.fin  = 1'b0;
    e.st   = ST_OK;
    step_beats.push_back(e);
  endfunction

  function automatic void emit_byte(logic [7:0] d);
    window_mem[out_cnt % WINDOW_DEPTH] = d;
    out_cnt++;
    put_beat(d, 1'b1);
  endfunction

  function automatic void replay_literals();
    while (tpos < BLOCK_TOKENS && out_cnt < raw_sz) begin
      if (flags[tpos]) begin
        ph = PH_EXTRAS;
        ext_seen = 0;
        lo_ext = '0;
        return;
      end
      emit_byte(tok_mem[tpos]);
      tpos++;
    end
    if (out_cnt >= raw_sz) begin
      ph = PH_DONE;
    end else begin
      ph = PH_FLAGS;
      flags = '0;
      fill = 0;
    end
  endfunction

  function automatic void copy_match(logic [7:0] tok, int unsigned ofs);
    int unsigned len, src;
    len = int'(tok & LEN_MASK) + MIN_MATCH_LEN;
    if (ofs > blk_start) begin
      if (err == ST_OK) err = ST_OFFSET;
      ph = PH_DONE;
      return;
    end
    src = blk_start - ofs;
    for (int unsigned i = 0; i < len && out_cnt < raw_sz; i++)
      emit_byte(window_mem[(src + i) % WINDOW_DEPTH]);
    tpos++;
    ext_seen = 0;
    lo_ext = '0;
    replay_literals();
  endfunction

  function automatic void clear_stream();
    flags = '0;
    foreach (tok_mem[i]) tok_mem[i] = '0;
    ph = PH_FLAGS;
    fill = 0;
    tpos = 0;
    lo_ext = '0;
    ext_seen = 0;
    out_cnt = 0;
    blk_start = 0;
    err = ST_OK;
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic fin);
    logic [7:0] tok;
    status_e    st;
    step_beats.delete();
    if (ph == PH_FLAGS && fill == 0 && out_cnt >= raw_sz) ph = PH_DONE;
    case (ph)
      PH_FLAGS: begin
        flags |= 16'(b) << (BYTE_BITS * fill);
        fill++;
        if (fill >= (BLOCK_TOKENS + 7) / 8) begin
          fill = 0;
          ph = PH_TOKENS;
        end
      end
      PH_TOKENS: begin
        tok_mem[fill] = b;
        fill++;
        if (fill >= BLOCK_TOKENS) begin
          fill = 0;
          tpos = 0;
          blk_start = out_cnt;
          replay_literals();
        end
      end
      PH_EXTRAS: begin
        tok = tok_mem[tpos];
        if ((tok & LONG_MARK) != LONG_MARK) begin
          copy_match(tok, (int'(tok & LONG_MARK) << 3) | int'(b));
        end else if (!ext_seen) begin
          lo_ext = b;
          ext_seen = 1;
        end else begin
          copy_match(tok, ((int'(b) << 8) | int'(lo_ext)) + LONG_OFFSET_BASE);
        end
      end
      default: begin
        if (err == ST_OK) err = ST_LEN;
      end
    endcase
    if (fin) begin
      if (err != ST_OK) st = err;
      else if (ph == PH_DONE) st = ST_OK;
      else if (ph == PH_FLAGS && fill == 0) st = ST_LEN;
      else st = ST_TRUNC;
      if (step_beats.size() == 0) put_beat('0, 1'b0);
      step_beats[step_beats.size() - 1].fin = 1'b1;
      step_beats[step_beats.size() - 1].st  = st;
      clear_stream();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) awaited_q.push_back(step_beats[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    raw_beat_t want;
    if (!rst_ni) begin
      awaited_q.delete();
      clear_stream();
      raw_sz = 0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_RAW_SIZE)
        raw_sz = {1'b0, pwdata[30:0]};
      if (in_mon.valid && in_mon.ready)
        predict_beat(in_mon.comp_byte, in_mon.is_final);
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected beat data %h has %b last %b fin %b status %0d", $time,
                   out_mon.raw_byte, out_mon.has_byte, out_mon.run_end, out_mon.finished,
                   out_mon.status);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (want.data !== out_mon.raw_byte || want.has !== out_mon.has_byte ||
              want.last !== out_mon.run_end || want.fin !== out_mon.finished ||
              want.st !== out_mon.status) begin
            $display("%0t: expected data %h has %b last %b fin %b status %0d, got data %h has %b last %b fin %b status %0d",
                     $time, want.data, want.has, want.last, want.fin, want.st,
                     out_mon.raw_byte, out_mon.has_byte, out_mon.run_end,
                     out_mon.finished, out_mon.status);
            fail_count++;
          end
        end
      end
      pending = awaited_q.size();
    end
  end

endmodule

[dv/block_lz_decompressor_tb.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, stream stimulus and verdict for the LZ block decompressor.
module block_lz_decompressor_tb;
  import blz_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;

  blz_in_if  in_bus ();
  blz_out_if out_bus ();

  block_lz_decompressor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  blz_scoreboard chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle and stall odds in percent, changed per phase as the beat count grows.
  int unsigned src_idle, snk_stall;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req;
  int unsigned hold_left;
  // Raw bytes known to be written into the window by earlier clean streams.
  int unsigned win_written;
  int          beats_sent;
  logic [7:0]  stream_q[$];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: stall at random, or hold off for a long stretch on request so that
  // the block fills up and has to refuse input.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // APB write with a setup and an access phase; the register takes the value at the access edge.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain every awaited beat, then let the block settle on any trailing work.
  task automatic drain_then_set_size(input logic [30:0] sz);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    apb_write({REG_RAW_SIZE, 2'b00}, {1'b0, sz});
  endtask

  // Offer one compressed beat; keep valid high across back-to-back beats.
  // The idling phase advances every 45 beats: none, sender, receiver, both.
  task automatic send_beat(input logic [7:0] b, input logic fin);
    case ((beats_sent / 45) % 4)
      0: begin src_idle = 0;  snk_stall = 0;  end
      1: begin src_idle = 71; snk_stall = 0;  end
      2: begin src_idle = 0;  snk_stall = 71; end
      default: begin src_idle = 36; snk_stall = 36; end
    endcase
    if ($urandom_range(99) < src_idle) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    in_bus.valid     <= 1'b1;
    in_bus.comp_byte <= b;
    in_bus.is_final  <= fin;
    do @(posedge clk_i); while (!in_bus.ready);
    beats_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_beat(stream_q[i], i == stream_q.size() - 1);
    in_bus.valid <= 1'b0;
  endtask

  // Build a well-formed stream of nblk blocks into stream_q. Matches point back
  // into bytes already produced, unless bad_pct picks an offset before the start.
  // A deep stream is all full-length matches after a literal block, so that it
  // grows past the long-offset base quickly.
  task automatic build_stream(input int nblk, input bit deep, input int bad_pct,
                              output int unsigned produced, output bit broken);
    logic [15:0] fl;
    logic [7:0]  toks[BLOCK_TOKENS];
    logic [7:0]  extra_q[$];
    int unsigned bstart, len, ofs, top;
    bit          lng;
    stream_q.delete();
    produced = 0;
    broken   = 0;
    for (int blk = 0; blk < nblk; blk++) begin
      bstart = produced;
      fl = deep ? ((blk == 0) ? 16'h0000 : 16'hffff) : 16'($urandom);
      extra_q.delete();
      for (int t = 0; t < BLOCK_TOKENS; t++) begin
        if (fl[t]) begin
          len = deep ? 31 : $urandom_range(31);
          lng = 0;
          if ($urandom_range(99) < bad_pct) begin
            // Offset before the start of output: latch the error, stop output.
            if (bstart < 1791 && $urandom_range(1)) begin
              ofs = $urandom_range(1791, bstart + 1);
            end else begin
              lng = 1;
              ofs = $urandom_range(1) ? LONG_OFFSET_BASE + 65535 :
                    $urandom_range(LONG_OFFSET_BASE + 65535,
                                   (bstart < LONG_OFFSET_BASE) ? LONG_OFFSET_BASE : bstart + 1);
            end
            broken = 1;
          end else if ((t > 0 || bstart + len + MIN_MATCH_LEN <= win_written) &&
                       $urandom_range(5) == 0) begin
            // Copy from the block start itself: old window content or earlier tokens.
            ofs = 0;
          end else if (bstart == 0) begin
            fl[t] = 1'b0;
          end else if (bstart >= LONG_OFFSET_BASE && $urandom_range(1)) begin
            lng = 1;
            top = (bstart > LONG_OFFSET_BASE + 65535) ? LONG_OFFSET_BASE + 65535 : bstart;
            ofs = $urandom_range(top, LONG_OFFSET_BASE);
          end else begin
            ofs = $urandom_range((bstart > 1791) ? 1791 : bstart, 1);
          end
          if (fl[t]) begin
            if (lng) begin
              toks[t] = LONG_MARK | 8'(len);
              extra_q.push_back(8'(ofs - LONG_OFFSET_BASE));
              extra_q.push_back(8'((ofs - LONG_OFFSET_BASE) >> 8));
            end else begin
              toks[t] = 8'((ofs >> 8) << 5) | 8'(len);
              extra_q.push_back(8'(ofs));
            end
            if (!broken) produced += len + MIN_MATCH_LEN;
          end
        end
        if (!fl[t]) begin
          toks[t] = 8'($urandom);
          if (!broken) produced++;
        end
      end
      stream_q.push_back(fl[7:0]);
      stream_q.push_back(fl[15:8]);
      foreach (toks[i]) stream_q.push_back(toks[i]);
      foreach (extra_q[i]) stream_q.push_back(extra_q[i]);
    end
  endtask

  initial begin
    int unsigned produced, sz, keep;
    bit          broken;
    int          ending, stream_no;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_bus.valid = 1'b0;
    in_bus.comp_byte = '0;
    in_bus.is_final  = 1'b0;
    out_bus.ready    = 1'b0;
    src_idle     = 0;
    snk_stall    = 0;
    hold_req     = 0;
    hold_left    = 0;
    win_written  = 0;
    beats_sent   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one literal block with extreme byte values, ending exactly.
    stream_q.delete();
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    for (int i = 0; i < BLOCK_TOKENS; i++)
      stream_q.push_back((i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom));
    drain_then_set_size(31'd16);
    send_stream();
    win_written = 16;

    // Directed: any byte with raw_size zero is excess input.
    stream_q.delete();
    stream_q.push_back(8'ha5);
    drain_then_set_size(31'd0);
    send_stream();

    // Directed: stream ending inside a block, largest raw_size.
    stream_q.delete();
    stream_q.push_back(8'hff);
    stream_q.push_back(8'h5a);
    stream_q.push_back(8'h3c);
    drain_then_set_size(31'h7fffffff);
    send_stream();

    // Random: well-formed streams with random content, ends and sizes; the deep
    // stream runs across the later idling phases.
    stream_no = 0;
    while (beats_sent < 120) begin
      build_stream((stream_no % 3 == 1) ? 6 : $urandom_range(2, 1), stream_no % 3 == 1,
                   ($urandom_range(3) == 0) ? 10 : 0, produced, broken);
      ending = $urandom_range(9);
      if (ending == 0) begin
        keep = $urandom_range(stream_q.size() - 1, 1);
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end else if (ending == 1) begin
        repeat ($urandom_range(3, 1)) stream_q.push_back(8'($urandom));
      end
      case ($urandom_range(7))
        0:       sz = (produced > 1) ? $urandom_range(produced - 1, 1) : produced;
        1:       sz = produced + $urandom_range(40, 1);
        2:       sz = 0;
        3:       sz = 32'h7fffffff;
        default: sz = produced;
      endcase
      drain_then_set_size(31'(sz));
      if (stream_no == 0) hold_req = 1;
      send_stream();
      if (!broken && ending != 0) begin
        keep = (sz < produced) ? sz : produced;
        if (keep > win_written) win_written = keep;
      end
      stream_no++;
    end

    // Let every awaited beat arrive, then allow for the block's latency.
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/blz_pkg.sv
hw/rtl/blz_if.sv
hw/rtl/blz_ram.sv
hw/rtl/blz_ctrl.sv
hw/rtl/blz_datapath.sv
hw/rtl/block_lz_decompressor.sv
dv/blz_scoreboard.sv
dv/block_lz_decompressor_tb.sv
